// ===== hdl/mmsl_pkg.sv =====
`default_nettype none
package mmsl_pkg;

  // default offset bound of one text
  localparam int MAX_TEXT_BYTES_DEF = 65536;

  // depth of the token queue at the output
  localparam int TOKEN_QUEUE_DEPTH = 8;

  // most tokens that one byte can cause
  localparam int MAX_TOKENS_PER_BYTE = 3;

  // token kinds
  localparam logic [3:0] KIND_TEXT     = 4'd0;
  localparam logic [3:0] KIND_STAR     = 4'd1;
  localparam logic [3:0] KIND_PIPE     = 4'd2;
  localparam logic [3:0] KIND_DASH     = 4'd3;
  localparam logic [3:0] KIND_BANG     = 4'd4;
  localparam logic [3:0] KIND_LBRACKET = 4'd5;
  localparam logic [3:0] KIND_RBRACKET = 4'd6;
  localparam logic [3:0] KIND_LPAREN   = 4'd7;
  localparam logic [3:0] KIND_RPAREN   = 4'd8;
  localparam logic [3:0] KIND_BACKTICK = 4'd9;
  localparam logic [3:0] KIND_NEWLINE  = 4'd10;
  localparam logic [3:0] KIND_EOF      = 4'd11;

  // characters
  localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
  localparam logic [7:0] CHAR_STAR     = 8'h2A;
  localparam logic [7:0] CHAR_PIPE     = 8'h7C;
  localparam logic [7:0] CHAR_DASH     = 8'h2D;
  localparam logic [7:0] CHAR_BANG     = 8'h21;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_LPAREN   = 8'h28;
  localparam logic [7:0] CHAR_RPAREN   = 8'h29;
  localparam logic [7:0] CHAR_BACKTICK = 8'h60;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;

  // lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_RUN      = 3'd1,
    MODE_DOLLAR   = 3'd2,
    MODE_SINGLE   = 3'd3,
    MODE_DOUBLE   = 3'd4,
    MODE_DOUBLE_D = 3'd5
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic        position_overflow;
    logic        run_end;
  } token_item_t;

  // kind of a one-byte markup token, text for anything else
  function automatic logic [3:0] markup_kind(logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      CHAR_STAR:     k = KIND_STAR;
      CHAR_PIPE:     k = KIND_PIPE;
      CHAR_DASH:     k = KIND_DASH;
      CHAR_BANG:     k = KIND_BANG;
      CHAR_LBRACKET: k = KIND_LBRACKET;
      CHAR_RBRACKET: k = KIND_RBRACKET;
      CHAR_LPAREN:   k = KIND_LPAREN;
      CHAR_RPAREN:   k = KIND_RPAREN;
      CHAR_BACKTICK: k = KIND_BACKTICK;
      CHAR_NEWLINE:  k = KIND_NEWLINE;
      default:       k = KIND_TEXT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/markdown_math_span_lexer.sv =====
`default_nettype none
// Markdown lexer with $...$ and $$...$$ math spans. It takes one text byte
// per transaction on the byte channel (final_byte marks the last byte of a
// text) and gives tokens (kind, start offset, length) on the token channel,
// run_end marking the last token caused by a byte. Each byte is decoded
// combinationally and its zero to three tokens are written at once into an
// eight-entry token queue, which gives one token per cycle when token_stall
// is low. A byte can be taken in every cycle while at least three queue
// entries are free; a byte that closes a run with a markup byte and ends the
// text makes the longest burst, three tokens. After the final byte all lexer
// state returns to reset for the next text. Offsets past MAX_TEXT_BYTES-1
// are held there and set position_overflow.
module markdown_math_span_lexer #(
  parameter int MAX_TEXT_BYTES = mmsl_pkg::MAX_TEXT_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   byte_valid,
  output logic                  byte_stall,
  input  mmsl_pkg::byte_item_t  byte_item,
  output logic                  token_valid,
  input  wire                   token_stall,
  output mmsl_pkg::token_item_t token_item
);
  import mmsl_pkg::*;

  localparam int SW = $clog2(MAX_TEXT_BYTES);
  localparam int PW = SW + 1;
  localparam int WS = (SW > 16) ? SW : 16;
  localparam int WL = (PW > 17) ? PW : 17;
  localparam logic [PW-1:0] LIM = PW'(MAX_TEXT_BYTES - 1);
  localparam int QD = TOKEN_QUEUE_DEPTH;
  localparam int QPW = $clog2(QD);
  localparam int QCW = QPW + 1;
  localparam int NT = MAX_TOKENS_PER_BYTE;

  function automatic logic [15:0] to_start(logic [SW-1:0] v);
    logic [WS-1:0] w;
    w = WS'(v);
    return w[15:0];
  endfunction

  function automatic logic [16:0] to_len(logic [PW-1:0] v);
    logic [WL-1:0] w;
    w = WL'(v);
    return w[16:0];
  endfunction

  // lexer state
  lex_mode_t    mode;
  logic [PW-1:0] byte_position;
  logic [SW-1:0] span_start;
  logic          overflow_seen;

  lex_mode_t     mode_eff;
  lex_mode_t     mode_next;
  logic [SW-1:0] span_next;

  // token queue
  token_item_t   queue [QD];
  logic [QPW-1:0] head;
  logic [QPW-1:0] tail;
  logic [QCW-1:0] count;

  logic          accept;
  logic          pop;
  logic          over_now;
  logic          ov1;
  logic [PW-1:0] idx;
  logic [SW-1:0] idx_s;
  logic [PW-1:0] eofpos;
  logic          eof_over;
  logic [SW-1:0] eof_start;
  logic [PW-1:0] len_run;
  logic [PW-1:0] len_close;
  logic [PW-1:0] len_flush;
  logic [3:0]    kind;
  logic          is_dollar;
  logic          is_markup;
  token_item_t   res [NT];
  logic [1:0]    n;

  assign accept = byte_valid && !byte_stall;
  assign pop    = token_valid && !token_stall;

  // offset of this byte, held at the bound
  assign over_now  = byte_position > LIM;
  assign ov1       = overflow_seen | over_now;
  assign idx       = over_now ? LIM : byte_position;
  assign idx_s     = idx[SW-1:0];
  assign eofpos    = idx + PW'(1);
  assign eof_over  = eofpos > LIM;
  assign eof_start = eof_over ? LIM[SW-1:0] : eofpos[SW-1:0];

  // byte class
  assign kind      = markup_kind(byte_item.text_byte);
  assign is_dollar = byte_item.text_byte == CHAR_DOLLAR;
  assign is_markup = kind != KIND_TEXT;

  // span lengths
  assign len_run   = {1'b0, idx_s} - {1'b0, span_start};
  assign len_close = {1'b0, idx_s} + PW'(1) - {1'b0, span_start};
  assign len_flush = {1'b0, idx_s} + PW'(1) - {1'b0, span_next};

  // codes with no meaning act as idle
  always_comb begin
    mode_eff = mode;
    if (mode > MODE_DOUBLE_D) begin
      mode_eff = MODE_IDLE;
    end
  end

  // next mode and span start
  always_comb begin
    mode_next = mode_eff;
    span_next = span_start;
    unique case (mode_eff)
      MODE_IDLE: begin
        if (is_dollar) begin
          mode_next = MODE_DOLLAR;
          span_next = idx_s;
        end else if (!is_markup) begin
          mode_next = MODE_RUN;
          span_next = idx_s;
        end
      end
      MODE_RUN: begin
        if (is_dollar) begin
          mode_next = MODE_DOLLAR;
          span_next = idx_s;
        end else if (is_markup) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_DOLLAR: begin
        mode_next = is_dollar ? MODE_DOUBLE : MODE_SINGLE;
      end
      MODE_SINGLE: begin
        if (is_dollar) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_DOUBLE: begin
        if (is_dollar) begin
          mode_next = MODE_DOUBLE_D;
        end
      end
      MODE_DOUBLE_D: begin
        mode_next = is_dollar ? MODE_IDLE : MODE_DOUBLE;
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // tokens caused by this byte
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      res[i] = '0;
    end
    n = 2'd0;
    unique case (mode_eff)
      MODE_IDLE: begin
        if (!is_dollar && is_markup) begin
          res[n] = '{kind, to_start(idx_s), 17'd1, ov1, 1'b0};
          n = n + 2'd1;
        end
      end
      MODE_RUN: begin
        if (is_dollar || is_markup) begin
          res[n] = '{KIND_TEXT, to_start(span_start), to_len(len_run), ov1, 1'b0};
          n = n + 2'd1;
        end
        if (!is_dollar && is_markup) begin
          res[n] = '{kind, to_start(idx_s), 17'd1, ov1, 1'b0};
          n = n + 2'd1;
        end
      end
      MODE_SINGLE, MODE_DOUBLE_D: begin
        if (is_dollar) begin
          res[n] = '{KIND_TEXT, to_start(span_start), to_len(len_close), ov1, 1'b0};
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase
    // end of text: flush an open run or span, then eof
    if (byte_item.final_byte) begin
      if (mode_next != MODE_IDLE) begin
        res[n] = '{KIND_TEXT, to_start(span_next), to_len(len_flush), ov1, 1'b0};
        n = n + 2'd1;
      end
      res[n] = '{KIND_EOF, to_start(eof_start), 17'd0, ov1 | eof_over, 1'b0};
      n = n + 2'd1;
    end
    for (int i = 0; i < NT; i++) begin
      res[i].run_end = (2'(i) == n - 2'd1);
    end
  end

  // lexer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_position <= '0;
      span_start    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (byte_item.final_byte) begin
        mode          <= MODE_IDLE;
        byte_position <= '0;
        span_start    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        mode          <= mode_next;
        byte_position <= idx + PW'(1);
        span_start    <= span_next;
        overflow_seen <= ov1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NT; i++) begin
        if (2'(i) < n) begin
          queue[tail + QPW'(i)] <= res[i];
        end
      end
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + QPW'(n);
      end
      if (pop) begin
        head <= head + QPW'(1);
      end
      count <= count + (accept ? QCW'(n) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));
    end
  end

  // channel outputs
  assign byte_stall  = count > QCW'(QD - NT);
  assign token_valid = count != '0;
  assign token_item  = queue[head];

endmodule
`default_nettype wire
